// ----- design/vnrm_pkg.sv -----
// ----------------------------------------------------------------------------
// vnrm_pkg: shared types for the vector norm running median block
// Sample and result word layouts, the ring entry layout and the sequencer
// states.
// ----------------------------------------------------------------------------
`default_nettype none

package vnrm_pkg;

	typedef struct packed {
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic signed [15:0] sample_z;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] median_x;
		logic signed [15:0] median_y;
		logic signed [15:0] median_z;
		logic [31:0]        median_norm_sq;
		logic [5:0]         window_fill;
	} result_t;

	typedef struct packed {
		sample_t     vec;
		logic [31:0] norm;
	} ring_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_SORT,
		ST_FLUSH,
		ST_MED_RD,
		ST_MED_WAIT,
		ST_SEARCH,
		ST_RESULT
	} fsm_state_t;

endpackage

`default_nettype wire

// ----- design/vector_norm_running_median_top.sv -----
// ----------------------------------------------------------------------------
// vector_norm_running_median_top: sliding-window median of sample norms
// Squares and sums each 3-axis sample, keeps the last WINDOW samples and
// their sorted norms, and reports the median norm with its newest vector.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel sample_valid/sample_ready/sample carries one 3-axis word.
//   Output channel result_valid/result_ready/result carries one result word
//   per input word: the norm at sorted position fill/2, the vector of the
//   newest held sample with that norm, and the fill count.
//   One word is worked on at a time; sample_ready is high only in idle.
//   Per word: the norm is formed with one shared squarer (three squares),
//   the new norm is merged into the sorted norm memory (one read and one
//   write per cycle plus read pipeline fill and drain), the median is read,
//   the sample ring is walked back from the newest entry to the first one
//   with the median norm, and the result is handed off.
//   The result sits in an output register; a new word is taken while it
//   waits, and a stalled receiver holds the block only at the final hand-off.
//   Reset empties the window (fill and write slot to zero); the memories
//   need no clearing since no unwritten entry is ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_norm_running_median_top
	import vnrm_pkg::*;
#(
	parameter int WINDOW = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW);

	fsm_state_t state_q, state_d;

	// datapath
	sample_t          sample_q;
	sample_t          found_q;
	logic [1:0]       step_q;
	logic [31:0]      prod_s1;
	logic [31:0]      norm_q;
	logic [31:0]      old_q;
	logic [31:0]      hold_q;
	logic [31:0]      med_q;
	logic [IDX_W-1:0] srch_q;
	result_t          out_q;

	// control
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] wr_ptr_q;
	logic             rd_vld_s1;
	logic             ins_q;
	logic             drop_q;
	logic             hold_vld_q;
	logic             out_vld_q;

	// memories
	logic [31:0] sort_mem [WINDOW];
	logic [31:0] sort_rd_q;
	ring_t       ring_mem [WINDOW];
	ring_t       ring_rd_q;

	logic             sort_we;
	logic [31:0]      sort_wd;
	logic [IDX_W-1:0] sort_ra;
	logic             ring_we;
	logic [IDX_W-1:0] ring_ra;

	logic               full;
	logic               drop;
	logic               ins_now;
	logic               accept;
	logic               load_out;
	logic               issue;
	logic signed [15:0] comp;
	logic signed [31:0] comp_w;
	logic signed [31:0] sq_w;

	assign full    = (fill_q == FULL_CNT);
	assign accept  = sample_valid && sample_ready;
	assign issue   = (rd_ptr_q < fill_q);
	// drop the first sorted copy of the outgoing norm when the window is full
	assign drop    = full && !drop_q && (sort_rd_q == old_q);
	assign ins_now = !ins_q && (norm_q < sort_rd_q);

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = out_vld_q;
	assign result       = out_q;

	// shared squarer
	always_comb begin
		case (step_q)
			2'd0:    comp = sample_q.sample_x;
			2'd1:    comp = sample_q.sample_y;
			default: comp = sample_q.sample_z;
		endcase
		comp_w = 32'(comp);
		sq_w   = comp_w * comp_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sort_we  = 1'b0;
		sort_wd  = norm_q;
		sort_ra  = rd_ptr_q[IDX_W-1:0];
		ring_we  = 1'b0;
		ring_ra  = slot_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (step_q == 2'd3) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				if (rd_vld_s1) begin
					if (hold_vld_q) begin
						sort_we = 1'b1;
						sort_wd = hold_q;
					end else if (ins_now) begin
						sort_we = 1'b1;
						sort_wd = norm_q;
					end else if (!drop) begin
						sort_we = 1'b1;
						sort_wd = sort_rd_q;
					end
				end else if (!issue) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!ins_q) begin
					sort_we = 1'b1;
					sort_wd = norm_q;
				end else if (hold_vld_q) begin
					sort_we = 1'b1;
					sort_wd = hold_q;
				end
				ring_we = 1'b1;
				state_d = ST_MED_RD;
			end
			ST_MED_RD: begin
				sort_ra = IDX_W'(fill_q >> 1);
				state_d = ST_MED_WAIT;
			end
			ST_MED_WAIT: begin
				ring_ra = slot_q;
				state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				ring_ra = srch_q;
				if (ring_rd_q.norm == med_q) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_vld_q || result_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			slot_q     <= '0;
			fill_q     <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			rd_vld_s1  <= 1'b0;
			ins_q      <= 1'b0;
			drop_q     <= 1'b0;
			hold_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q     <= '0;
						rd_ptr_q   <= '0;
						wr_ptr_q   <= '0;
						rd_vld_s1  <= 1'b0;
						ins_q      <= 1'b0;
						drop_q     <= 1'b0;
						hold_vld_q <= 1'b0;
					end
				end
				ST_NORM: begin
					step_q <= step_q + 2'd1;
				end
				ST_SORT: begin
					rd_vld_s1 <= issue;
					if (issue) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (rd_vld_s1) begin
						if (sort_we) begin
							wr_ptr_q <= wr_ptr_q + 1'b1;
						end
						if (drop) begin
							drop_q <= 1'b1;
						end
						if (hold_vld_q) begin
							hold_vld_q <= !drop;
						end else if (ins_now) begin
							ins_q      <= 1'b1;
							hold_vld_q <= !drop;
						end
					end
				end
				ST_FLUSH: begin
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
				end
				ST_RESULT: begin
					if (load_out) begin
						slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
		if (state_q == ST_NORM) begin
			prod_s1 <= 32'(sq_w);
			if (step_q == 2'd0) begin
				norm_q <= '0;
				old_q  <= ring_rd_q.norm;
			end else begin
				norm_q <= norm_q + prod_s1;
			end
		end
		// park the current element behind an inserted norm
		if (state_q == ST_SORT && rd_vld_s1 && !drop && (hold_vld_q || ins_now)) begin
			hold_q <= sort_rd_q;
		end
		if (state_q == ST_MED_WAIT) begin
			med_q  <= sort_rd_q;
			srch_q <= (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
		end
		if (state_q == ST_SEARCH) begin
			srch_q <= (srch_q == '0) ? LAST_SLOT : srch_q - 1'b1;
			if (ring_rd_q.norm == med_q) begin
				found_q <= ring_rd_q.vec;
			end
		end
		if (load_out) begin
			out_q.median_x       <= found_q.sample_x;
			out_q.median_y       <= found_q.sample_y;
			out_q.median_z       <= found_q.sample_z;
			out_q.median_norm_sq <= med_q;
			out_q.window_fill    <= 6'(fill_q);
		end
	end

	// sorted norm memory
	always_ff @(posedge clk) begin
		if (sort_we) begin
			sort_mem[wr_ptr_q[IDX_W-1:0]] <= sort_wd;
		end
		sort_rd_q <= sort_mem[sort_ra];
	end

	// sample ring memory
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[slot_q] <= '{vec: sample_q, norm: norm_q};
		end
		ring_rd_q <= ring_mem[ring_ra];
	end

endmodule

`default_nettype wire

// ----- design/vnrm_checker.sv -----
// ----------------------------------------------------------------------------
// vnrm_checker: port-level checks for the vector norm running median block
// Watches both channels and the result fill count; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vnrm_checker
	import vnrm_pkg::*;
#(
	parameter int WINDOW = 32
) (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_valid,
	input logic    sample_ready,
	input sample_t sample,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = sample_valid && sample_ready;
	assign out_acc = result_valid && result_ready;

	// count words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pend_q != 2'd0))
		else $error("result word without a matching sample word");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !sample_ready)
		else $error("sample word taken while previous one still in work");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((WINDOW > 63) ||
			((result.window_fill != 6'd0) && (result.window_fill <= 6'(WINDOW)))))
		else $error("window fill out of range");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=> (result_valid && $stable(result)))
		else $error("stalled result word dropped or changed");

endmodule

bind vector_norm_running_median_top vnrm_checker #(.WINDOW(WINDOW)) u_vnrm_checker (.*);

`default_nettype wire
